@@ src/mono_note_priority_stack_macros.svh @@
// Assertion macros shared by the note stack checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MONO_NOTE_PRIORITY_STACK_MACROS_SVH
`define MONO_NOTE_PRIORITY_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MNPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MNPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mnps_pkg.sv @@
// Shared types, constants and microcode ROM for the mono note priority stack.
// No dependencies; imported by the sequencer, the top level and the checker.
package mnps_pkg;

    localparam int DEF_STACK_DEPTH = 8;

    localparam logic [6:0] ACCENT_VELOCITY = 7'd100;
    localparam logic [4:0] MAX_CHANNEL     = 5'd1;

    // Event command codes
    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] channel;
        logic [6:0] note_number;
        logic [6:0] velocity;
    } in_item_t;

    typedef struct packed {
        logic       gate_on;
        logic [6:0] live_note;
        logic       accent_on;
        logic       slide_on;
        logic [3:0] held_count;
    } out_item_t;

    // One stack entry as stored in the RAM
    typedef struct packed {
        logic [6:0] note;
        logic       accent;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Microprogram step addresses
    localparam logic [3:0] UP_IDLE     = 4'd0;
    localparam logic [3:0] UP_CHK_CLR  = 4'd1;
    localparam logic [3:0] UP_CHK_IGN  = 4'd2;
    localparam logic [3:0] UP_SRCH_RD  = 4'd3;
    localparam logic [3:0] UP_SRCH_CMP = 4'd4;
    localparam logic [3:0] UP_SHIFT_RD = 4'd5;
    localparam logic [3:0] UP_SHIFT_WR = 4'd6;
    localparam logic [3:0] UP_DEC      = 4'd7;
    localparam logic [3:0] UP_BRANCH   = 4'd8;
    localparam logic [3:0] UP_PUSH     = 4'd9;
    localparam logic [3:0] UP_REL_RD   = 4'd10;
    localparam logic [3:0] UP_REL_SET  = 4'd11;
    localparam logic [3:0] UP_REL_OFF  = 4'd12;
    localparam logic [3:0] UP_EMIT     = 4'd13;
    localparam logic [3:0] UP_CLEAR    = 4'd14;

    // Sequencer branch conditions
    localparam logic [3:0] C_NEXT      = 4'd0;
    localparam logic [3:0] C_JUMP      = 4'd1;
    localparam logic [3:0] C_WAIT_IN   = 4'd2;
    localparam logic [3:0] C_WAIT_OUT  = 4'd3;
    localparam logic [3:0] C_IF_CLEAR  = 4'd4;
    localparam logic [3:0] C_IF_IGNORE = 4'd5;
    localparam logic [3:0] C_IF_IDX_END = 4'd6;
    localparam logic [3:0] C_IF_MISS   = 4'd7;
    localparam logic [3:0] C_IF_LAST   = 4'd8;
    localparam logic [3:0] C_IF_OFF    = 4'd9;
    localparam logic [3:0] C_IF_EMPTY  = 4'd10;

    // Datapath action bits of one control word
    typedef struct packed {
        logic in_ready;
        logic idx_clr;
        logic rd_idx1;
        logic rd_top;
        logic wr_shift;
        logic idx_inc;
        logic idx_inc_miss;
        logic depth_dec;
        logic push;
        logic load_top;
        logic gate_off;
        logic clr;
        logic emit;
    } uact_t;

    typedef struct packed {
        logic [3:0] cond;
        logic [3:0] target;
        uact_t      act;
    } uword_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic is_clear;
        logic is_ignore;
        logic idx_end;
        logic miss;
        logic last;
        logic is_off;
        logic empty;
    } ucond_t;

    // Control store
    function automatic uword_t ucode_rom(input logic [3:0] step);
        uword_t w;
        w = '0;
        case (step)
            UP_IDLE:
            begin
                w.cond = C_WAIT_IN;  w.target = UP_CHK_CLR;
                w.act.in_ready = 1'b1; w.act.idx_clr = 1'b1;
            end
            UP_CHK_CLR:
            begin
                w.cond = C_IF_CLEAR; w.target = UP_CLEAR;
            end
            UP_CHK_IGN:
            begin
                w.cond = C_IF_IGNORE; w.target = UP_EMIT;
            end
            UP_SRCH_RD:
            begin
                // default read address is the search index
                w.cond = C_IF_IDX_END; w.target = UP_BRANCH;
            end
            UP_SRCH_CMP:
            begin
                w.cond = C_IF_MISS; w.target = UP_SRCH_RD;
                w.act.idx_inc_miss = 1'b1;
            end
            UP_SHIFT_RD:
            begin
                w.cond = C_IF_LAST; w.target = UP_DEC;
                w.act.rd_idx1 = 1'b1;
            end
            UP_SHIFT_WR:
            begin
                w.cond = C_JUMP; w.target = UP_SHIFT_RD;
                w.act.wr_shift = 1'b1; w.act.idx_inc = 1'b1;
            end
            UP_DEC:
            begin
                w.cond = C_NEXT;
                w.act.depth_dec = 1'b1;
            end
            UP_BRANCH:
            begin
                w.cond = C_IF_OFF; w.target = UP_REL_RD;
            end
            UP_PUSH:
            begin
                w.cond = C_JUMP; w.target = UP_EMIT;
                w.act.push = 1'b1;
            end
            UP_REL_RD:
            begin
                w.cond = C_IF_EMPTY; w.target = UP_REL_OFF;
                w.act.rd_top = 1'b1;
            end
            UP_REL_SET:
            begin
                w.cond = C_JUMP; w.target = UP_EMIT;
                w.act.load_top = 1'b1;
            end
            UP_REL_OFF:
            begin
                w.cond = C_NEXT;
                w.act.gate_off = 1'b1;
            end
            UP_EMIT:
            begin
                w.cond = C_WAIT_OUT; w.target = UP_IDLE;
                w.act.emit = 1'b1;
            end
            UP_CLEAR:
            begin
                w.cond = C_JUMP; w.target = UP_EMIT;
                w.act.clr = 1'b1;
            end
            default:
            begin
                w.cond = C_JUMP; w.target = UP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/mnps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the note stack entries.
module mnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/mnps_seq.sv @@
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on mnps_pkg for the control word, condition codes and ROM.
module mnps_seq
    import mnps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ucond_t flags,
    output uact_t  act
);

    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    logic [3:0] pc_inc;
    uword_t     word;

    assign word   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + 4'd1;
    assign act    = word.act;

    // Next step selection
    always_comb
    begin
        case (word.cond)
            C_NEXT:       pc_next = pc_inc;
            C_JUMP:       pc_next = word.target;
            C_WAIT_IN:    pc_next = flags.in_valid  ? word.target : pc_reg;
            C_WAIT_OUT:   pc_next = flags.out_free  ? word.target : pc_reg;
            C_IF_CLEAR:   pc_next = flags.is_clear  ? word.target : pc_inc;
            C_IF_IGNORE:  pc_next = flags.is_ignore ? word.target : pc_inc;
            C_IF_IDX_END: pc_next = flags.idx_end   ? word.target : pc_inc;
            C_IF_MISS:    pc_next = flags.miss      ? word.target : pc_inc;
            C_IF_LAST:    pc_next = flags.last      ? word.target : pc_inc;
            C_IF_OFF:     pc_next = flags.is_off    ? word.target : pc_inc;
            C_IF_EMPTY:   pc_next = flags.empty     ? word.target : pc_inc;
            default:      pc_next = UP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ src/mono_note_priority_stack.sv @@
// Monophonic last-note-priority voice allocator (top level).
// Depends on mnps_pkg, mnps_seq and mnps_ram.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries note-on, note-off and
//   clear events; each transaction yields exactly one result on
//   out_valid/out_ready/out_data (gate, live note, accent, slide, count).
//   cfg_we/cfg_data write receive_enable; write it only while idle.
//   One event is processed at a time by a microcoded sequencer that walks
//   the held-note stack in a RAM with registered read, visiting each entry
//   with a read step and then a compare or move step. in_ready rises again
//   the cycle after the result is registered, and the result may still wait
//   in the output register while the next event is taken. If the receiver
//   stalls with a result pending, the next event is processed but holds in
//   its final step until the output frees.
//   Reset empties the stack, clears gate, note, accent and slide, and
//   sets receive_enable to 1. The RAM needs no clearing pass.
module mono_note_priority_stack
    import mnps_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    uact_t     act;
    ucond_t    flags;

    in_item_t  evt_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      enable_reg;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] depth_next;
    logic [6:0]    cur_note_reg;
    logic [6:0]    cur_note_next;
    logic          gate_reg;
    logic          gate_next;
    logic          accent_reg;
    logic          accent_next;
    logic          slide_reg;
    logic          slide_next;

    logic [CW-1:0] idx_plus1;
    logic [CW-1:0] depth_minus1;
    logic          full;
    logic          new_accent;
    logic          out_free;
    logic          accept;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    // Sequencer
    mnps_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .act   (act)
    );

    // Stack storage
    mnps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes
    assign in_ready  = act.in_ready;
    assign accept    = in_valid && act.in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Address arithmetic
    assign idx_plus1    = idx_reg + CW'(1);
    assign depth_minus1 = depth_reg - CW'(1);
    assign full         = (depth_reg == CW'(STACK_DEPTH));
    assign new_accent   = (evt_reg.velocity >= ACCENT_VELOCITY);

    // Status flags for branching
    always_comb
    begin
        flags.in_valid  = in_valid;
        flags.out_free  = out_free;
        flags.is_clear  = (evt_reg.cmd == CMD_CLEAR);
        flags.is_ignore = ((evt_reg.cmd != CMD_NOTE_ON) && (evt_reg.cmd != CMD_NOTE_OFF))
                          || !enable_reg || (evt_reg.channel > MAX_CHANNEL);
        flags.idx_end   = (idx_reg >= depth_reg);
        flags.miss      = (ram_rdata.note != evt_reg.note_number);
        flags.last      = (idx_plus1 >= depth_reg);
        flags.is_off    = (evt_reg.cmd == CMD_NOTE_OFF) || (evt_reg.velocity == 7'd0);
        flags.empty     = (depth_reg == '0);
    end

    // RAM port selection
    always_comb
    begin
        if (act.rd_idx1)
        begin
            ram_raddr = idx_plus1[AW-1:0];
        end
        else if (act.rd_top)
        begin
            ram_raddr = depth_minus1[AW-1:0];
        end
        else
        begin
            ram_raddr = idx_reg[AW-1:0];
        end

        ram_we = act.wr_shift || (act.push && !full);
        if (act.push)
        begin
            ram_waddr        = depth_reg[AW-1:0];
            ram_wdata.note   = evt_reg.note_number;
            ram_wdata.accent = new_accent;
        end
        else
        begin
            ram_waddr = idx_reg[AW-1:0];
            ram_wdata = ram_rdata;
        end
    end

    // Voice state update
    always_comb
    begin
        idx_next      = idx_reg;
        depth_next    = depth_reg;
        cur_note_next = cur_note_reg;
        gate_next     = gate_reg;
        accent_next   = accent_reg;
        slide_next    = slide_reg;

        if (act.idx_clr)
        begin
            idx_next = '0;
        end
        else if (act.idx_inc || (act.idx_inc_miss && flags.miss))
        begin
            idx_next = idx_plus1;
        end

        if (act.depth_dec)
        begin
            depth_next = depth_minus1;
        end

        if (act.push)
        begin
            if (!full)
            begin
                depth_next = depth_reg + CW'(1);
            end
            slide_next    = gate_reg && (cur_note_reg != evt_reg.note_number);
            accent_next   = new_accent;
            gate_next     = 1'b1;
            cur_note_next = evt_reg.note_number;
        end

        if (act.load_top)
        begin
            cur_note_next = ram_rdata.note;
            accent_next   = ram_rdata.accent;
            slide_next    = 1'b1;
        end

        if (act.gate_off || act.clr)
        begin
            gate_next  = 1'b0;
            slide_next = 1'b0;
        end

        if (act.clr)
        begin
            depth_next = '0;
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (act.emit && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            depth_reg     <= '0;
            cur_note_reg  <= '0;
            gate_reg      <= 1'b0;
            accent_reg    <= 1'b0;
            slide_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b1;
        end
        else
        begin
            idx_reg       <= idx_next;
            depth_reg     <= depth_next;
            cur_note_reg  <= cur_note_next;
            gate_reg      <= gate_next;
            accent_reg    <= accent_next;
            slide_reg     <= slide_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    // Event and result payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evt_reg <= in_data;
        end
        if (act.emit && out_free)
        begin
            out_reg.gate_on    <= gate_reg;
            out_reg.live_note  <= cur_note_reg;
            out_reg.accent_on  <= accent_reg;
            out_reg.slide_on   <= slide_reg;
            out_reg.held_count <= 4'(depth_reg);
        end
    end

endmodule

@@ src/mnps_checker.sv @@
// Port-level checker for the mono note priority stack, bound to the top level.
// Depends on mnps_pkg and mono_note_priority_stack_macros.svh.
`include "mono_note_priority_stack_macros.svh"

module mnps_checker
    import mnps_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // A stalled result holds its value
    `MNPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // One event in flight: ready drops after each accepted transaction
    `MNPS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second event taken while busy")

    // Stack never reports more entries than it holds (count wraps on deep stacks)
    `MNPS_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, (STACK_DEPTH > 15) || (out_data.held_count <= 4'(STACK_DEPTH)), "held count beyond stack depth")

    // Held notes or a slide imply an open gate
    `MNPS_ASSERT_NOW(a_gate_held, clk, rst_n, out_valid && ((out_data.held_count != 4'd0) || out_data.slide_on), out_data.gate_on, "gate closed with notes held or slide set")

endmodule

bind mono_note_priority_stack mnps_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_mnps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
